// ===== hw/rtl/esmv_pkg.sv =====
// ============================================================================
// esmv_pkg
// Shared types and constants of the ELLPACK sparse matrix-vector unit:
// channel payloads, controller states, and controller/datapath handshakes.
// ============================================================================
`default_nettype none

package esmv_pkg;

  // Item commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_MATRIX = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_IDX  = 2'd1;

  // Register reset values (Q16.16)
  localparam logic signed [31:0] ALPHA_RESET = 32'sd65536;
  localparam logic signed [31:0] BETA_RESET  = 32'sd0;

  // One input item
  typedef struct packed {
    logic               cmd;
    logic [9:0]         index;
    logic signed [31:0] item_value;
    logic               padding;
    logic               row_last;
    logic signed [31:0] prior_out;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic signed [31:0] out_value;
    logic [15:0]        out_row;
    logic               saturated;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_VALUE,
    S_MUL_X,
    S_ACC_TERM,
    S_MUL_PRIOR,
    S_ACC_PRIOR,
    S_EMIT
  } esmv_state_t;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MUL_ALPHA_VALUE,
    MUL_SCALED_X,
    MUL_BETA_PRIOR
  } mul_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     take_item;
    logic     load_x;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_cmd;
    logic in_padding;
    logic in_last;
    logic item_last;
    logic beta_zero;
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/esmv_stream_if.sv =====
// ============================================================================
// esmv_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ============================================================================
`default_nettype none

interface esmv_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/esmv_ram.sv =====
// ============================================================================
// esmv_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module esmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/esmv_ctrl.sv =====
// ============================================================================
// esmv_ctrl
// Sequencer: steps one matrix slot through the shared multiplier and the
// accumulator, then finishes the row into the output register.
// ============================================================================
`default_nettype none

module esmv_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire esmv_pkg::dp_status_t  status,
  output      esmv_pkg::ctrl_cmd_t   ctrl
);
  import esmv_pkg::*;

  esmv_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    ctrl         = '0;
    ctrl.mul_sel = MUL_ALPHA_VALUE;
    case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        ctrl.take_item = in_valid;
        if (in_valid && status.in_cmd == CMD_MATRIX) begin
          if (!status.in_padding) begin
            state_next = S_MUL_VALUE;
          end else if (status.in_last) begin
            state_next = status.beta_zero ? S_EMIT : S_MUL_PRIOR;
          end
        end
      end
      S_MUL_VALUE: begin
        ctrl.load_x  = 1'b1;
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_ALPHA_VALUE;
        state_next   = S_MUL_X;
      end
      S_MUL_X: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_SCALED_X;
        state_next   = S_ACC_TERM;
      end
      S_ACC_TERM: begin
        ctrl.acc_en = 1'b1;
        if (status.item_last) begin
          state_next = status.beta_zero ? S_EMIT : S_MUL_PRIOR;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL_PRIOR: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_BETA_PRIOR;
        state_next   = S_ACC_PRIOR;
      end
      S_ACC_PRIOR: begin
        ctrl.acc_en = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register can take the row
        if (!status.out_full) begin
          ctrl.emit  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/esmv_datapath.sv =====
// ============================================================================
// esmv_datapath
// Vector store, configuration registers, shared 32x32 multiplier, saturating
// 64-bit row accumulator, row counter and output register.
// ============================================================================
`default_nettype none

module esmv_datapath #(
  parameter int VEC_DEPTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [esmv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [esmv_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire esmv_pkg::in_item_t                  in_item,
  output      esmv_pkg::out_item_t                 out_item,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire esmv_pkg::ctrl_cmd_t                 ctrl,
  output      esmv_pkg::dp_status_t                status
);
  import esmv_pkg::*;

  localparam int ADDR_W = $clog2(VEC_DEPTH);
  localparam logic [16:0] DEPTH_LIM = 17'(VEC_DEPTH);
  localparam logic signed [63:0] MAX32_W = 64'sd2147483647;
  localparam logic signed [63:0] MIN32_W = -64'sd2147483648;
  localparam logic signed [63:0] MAX64   = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] MIN64   = {1'b1, {63{1'b0}}};

  // Saturating signed 64-bit add
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? MIN64 : MAX64;
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  logic signed [31:0] alpha;
  logic signed [31:0] beta;
  logic signed [31:0] item_value;
  logic signed [31:0] prior;
  logic               item_last;
  logic               item_in_range;
  logic signed [31:0] x_val;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic [15:0]        row_cnt;

  logic               in_range;
  logic [31:0]        rdata;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_out;
  logic signed [63:0] term;
  logic signed [31:0] scaled;
  logic               acc_hi;
  logic               acc_lo;

  assign in_range = 17'(in_item.index) < DEPTH_LIM;

  // Vector store: load on an in-range load transfer, read on every transfer
  esmv_ram #(
    .WIDTH (32),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ctrl.take_item && in_item.cmd == CMD_LOAD && in_range),
    .waddr (ADDR_W'(in_item.index)),
    .wdata (in_item.item_value),
    .re    (ctrl.take_item),
    .raddr (ADDR_W'(in_item.index)),
    .rdata (rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RESET;
      beta  <= BETA_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ALPHA_IDX) begin
        alpha <= signed'(cfg_data);
      end else if (cfg_index == CFG_BETA_IDX) begin
        beta <= signed'(cfg_data);
      end
    end
  end

  // Latch the slot being worked on
  always_ff @(posedge clk) begin
    if (ctrl.take_item) begin
      item_value    <= in_item.item_value;
      prior         <= in_item.prior_out;
      item_last     <= in_item.row_last;
      item_in_range <= in_range;
    end
  end

  // Vector operand; an out-of-range column reads zero
  always_ff @(posedge clk) begin
    if (ctrl.load_x) begin
      x_val <= item_in_range ? signed'(rdata) : 32'sd0;
    end
  end

  // Scaled value (alpha*value)>>16 clipped to 32 bits
  assign term   = prod >>> 16;
  assign scaled = (term > MAX32_W) ? 32'sh7FFF_FFFF :
                  (term < MIN32_W) ? 32'sh8000_0000 : term[31:0];

  // Shared multiplier operand select
  always_comb begin
    case (ctrl.mul_sel)
      MUL_ALPHA_VALUE: begin
        mul_a = alpha;
        mul_b = item_value;
      end
      MUL_SCALED_X: begin
        mul_a = scaled;
        mul_b = x_val;
      end
      MUL_BETA_PRIOR: begin
        mul_a = beta;
        mul_b = prior;
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_out;
    end
  end

  // Final clip of the row sum
  assign acc_hi = acc > MAX32_W;
  assign acc_lo = acc < MIN32_W;

  // Accumulator, row counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      row_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.emit) begin
        acc       <= '0;
        row_cnt   <= row_cnt + 16'd1;
        out_valid <= 1'b1;
      end else begin
        if (ctrl.acc_en) begin
          acc <= sat_add64(acc, term);
        end
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_item.out_value <= acc_hi ? 32'sh7FFF_FFFF :
                            acc_lo ? 32'sh8000_0000 : acc[31:0];
      out_item.out_row   <= row_cnt;
      out_item.saturated <= acc_hi || acc_lo;
    end
  end

  // Status to the controller
  assign status.in_cmd     = in_item.cmd;
  assign status.in_padding = in_item.padding;
  assign status.in_last    = in_item.row_last;
  assign status.item_last  = item_last;
  assign status.beta_zero  = (beta == 32'sd0);
  assign status.out_full   = out_valid && !out_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/ell_sparse_matvec_unit.sv =====
// ============================================================================
// ell_sparse_matvec_unit
// ELLPACK sparse matrix-vector multiply c = alpha*A*x + beta*c_old, Q16.16.
// A load or padding slot is taken in idle; a stored slot then steps through
// the vector read, two passes through the one shared 32x32 multiplier and
// the accumulate, taking no item meanwhile. A row-last slot adds an emit step,
// after beta*prior if beta is nonzero; the result is valid the cycle after it.
// Reset: alpha = 1.0, beta = 0, accumulator, row counter and output valid
// cleared; the vector store is not cleared and holds garbage until loaded.
// ============================================================================
`default_nettype none

module ell_sparse_matvec_unit #(
  parameter int VEC_DEPTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  esmv_stream_if.sink                          items,
  esmv_stream_if.source                        results,
  input  wire logic                            cfg_we,
  input  wire logic [esmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [esmv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import esmv_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;
  in_item_t   in_item;
  out_item_t  out_item;
  logic       out_valid;

  assign in_item         = items.payload;
  assign results.payload = out_item;
  assign results.valid   = out_valid;

  // Sequencer
  esmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // Arithmetic and storage
  esmv_datapath #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .ctrl      (ctrl),
    .status    (status)
  );

endmodule

`default_nettype wire

// ===== dv/matvec_result_checker.sv =====
// ============================================================================
// matvec_result_checker
// Watches the item, result and register ports of the ELLPACK matvec unit,
// predicts every row result from the accepted transfers and compares each
// result transfer field by field against the oldest outstanding row.
// ============================================================================

module matvec_result_checker #(
  parameter int VEC_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  input  logic                                item_ready,
  input  esmv_pkg::in_item_t                  item,
  input  logic                                result_valid,
  input  logic                                result_ready,
  input  esmv_pkg::out_item_t                 result,
  input  logic                                cfg_we,
  input  logic [esmv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [esmv_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                end_check,
  output int                                  mismatches,
  output int                                  pending_rows,
  output int                                  rows_checked,
  output int                                  rows_clipped
);
  timeunit 1ns;
  timeprecision 1ps;
  import esmv_pkg::*;

  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam longint Q_MAX   = 64'sd2147483647;
  localparam longint Q_MIN   = -64'sd2147483648;
  localparam int     PRINT_CAP = 40;

  // Predictor state: register copies, vector copy, row accumulator
  longint      alpha_q;
  longint      beta_q;
  longint      row_acc;
  logic [15:0] row_num;
  logic [31:0] vec_copy [VEC_DEPTH];
  out_item_t   expected_rows [$];

  int errs = 0;
  int checked = 0;
  int clipped = 0;
  bit leftovers_done = 1'b0;

  task automatic report_mismatch(input string what);
    if (errs < PRINT_CAP)
      $display("%0t ns: row mismatch: %s", $time, what);
    errs++;
  endtask

  // Arithmetic shift, rounding toward minus infinity
  function automatic longint shr16(input longint v);
    return v >>> 16;
  endfunction

  // Clip to the signed 32-bit range and flag the clip
  function automatic longint clip_q(input longint v, output bit hit);
    hit = 1'b0;
    if (v > Q_MAX) begin
      hit = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      hit = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  // Add into the accumulator, saturating at the signed 64-bit range
  function automatic longint acc_add(input longint a, input longint b);
    logic signed [64:0] s;
    s = a;
    s = s + b;
    if (s > ACC_MAX) return ACC_MAX;
    if (s < ACC_MIN) return ACC_MIN;
    return s[63:0];
  endfunction

  // Advance the predictor by one accepted item; queue a row when it closes
  task automatic step_matvec(input in_item_t it);
    longint    x;
    longint    scaled;
    longint    total;
    bit        hit;
    out_item_t row;
    if (it.cmd == CMD_LOAD) begin
      if (it.index < VEC_DEPTH)
        vec_copy[it.index] = it.item_value;
      return;
    end
    if (!it.padding) begin
      x = (it.index < VEC_DEPTH) ? longint'($signed(vec_copy[it.index])) : 0;
      scaled = clip_q(shr16(alpha_q * longint'($signed(it.item_value))), hit);
      row_acc = acc_add(row_acc, shr16(scaled * x));
    end
    if (!it.row_last)
      return;
    if (beta_q != 0)
      row_acc = acc_add(row_acc, shr16(beta_q * longint'($signed(it.prior_out))));
    total = clip_q(row_acc, hit);
    row.out_value = total[31:0];
    row.out_row   = row_num;
    row.saturated = hit;
    expected_rows.push_back(row);
    row_acc = 0;
    row_num = row_num + 16'd1;
  endtask

  // Compare one result transfer with the oldest outstanding row
  task automatic check_row(input out_item_t got);
    out_item_t want;
    if (expected_rows.size() == 0) begin
      report_mismatch($sformatf("row %0d came out with no row outstanding", got.out_row));
      return;
    end
    want = expected_rows.pop_front();
    checked++;
    if (want.saturated)
      clipped++;
    if (got.out_value !== want.out_value)
      report_mismatch($sformatf("row %0d out_value %h, predicted %h",
                                want.out_row, got.out_value, want.out_value));
    if (got.out_row !== want.out_row)
      report_mismatch($sformatf("out_row %0d, predicted %0d", got.out_row, want.out_row));
    if (got.saturated !== want.saturated)
      report_mismatch($sformatf("row %0d saturated %b, predicted %b",
                                want.out_row, got.saturated, want.saturated));
  endtask

  // Sample every port at the rising edge; publish counts by nonblocking update
  always @(posedge clk) begin
    if (rst) begin
      alpha_q = ALPHA_RESET;
      beta_q  = BETA_RESET;
      row_acc = 0;
      row_num = '0;
      expected_rows.delete();
    end else begin
      if (result_valid && result_ready)
        check_row(result);
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALPHA_IDX: alpha_q = $signed(cfg_data);
          CFG_BETA_IDX:  beta_q  = $signed(cfg_data);
          default: ;
        endcase
      end
      if (item_valid && item_ready)
        step_matvec(item);
      // Anything still outstanding at the end never came out
      if (end_check && !leftovers_done) begin
        leftovers_done = 1'b1;
        foreach (expected_rows[i])
          report_mismatch($sformatf("row %0d never came out", expected_rows[i].out_row));
        expected_rows.delete();
      end
    end
    mismatches   <= errs;
    pending_rows <= expected_rows.size();
    rows_checked <= checked;
    rows_clipped <= clipped;
  end

endmodule

// ===== dv/tb_ell_sparse_matvec_unit.sv =====
// ============================================================================
// tb_ell_sparse_matvec_unit
// Drives vector loads and ELLPACK row slots into the matvec unit under a
// series of alpha/beta settings and idle patterns, and reports the verdict
// from the checker's mismatch count.
// ============================================================================

module tb_ell_sparse_matvec_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import esmv_pkg::*;

  localparam int VEC_DEPTH     = 1024;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int RANDOM_PHASES = 6;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 5000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A_IDX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B_IDX = 2'd3;

  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] Q_HALF    = 32'h0000_8000;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  end_check;

  int send_idle_pct = 27;
  int recv_idle_pct = 68;
  int items_sent = 0;
  int rows_sent = 0;
  int settings_used = 1;

  int mismatches;
  int pending_rows;
  int rows_checked;
  int rows_clipped;

  logic [9:0] loaded_cols [$];
  bit         col_loaded [1024];

  esmv_stream_if #(.payload_t(in_item_t))  item_ch ();
  esmv_stream_if #(.payload_t(out_item_t)) result_ch ();

  ell_sparse_matvec_unit #(.VEC_DEPTH(VEC_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .items     (item_ch),
    .results   (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  matvec_result_checker #(.VEC_DEPTH(VEC_DEPTH)) row_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_ch.valid),
    .item_ready   (item_ch.ready),
    .item         (item_ch.payload),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .result       (result_ch.payload),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .end_check    (end_check),
    .mismatches   (mismatches),
    .pending_rows (pending_rows),
    .rows_checked (rows_checked),
    .rows_clipped (rows_clipped)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Hard stop well past the slowest passing run
  initial begin
    #(20_000_000);
    $display("timeout: %0d items sent, %0d rows outstanding", items_sent, pending_rows);
    $display("tb_ell_sparse_matvec_unit: errors");
    $finish;
  end

  // Result side: drop ready at random per the current idle rate
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Mostly small Q16.16 values, some full-range, some corners
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2:    return $urandom;
      default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  // Hold the item until the transfer, idling first at random
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.payload <= it;
    @(posedge clk);
    while (!item_ch.ready)
      @(posedge clk);
    items_sent++;
  endtask

  // Load one vector element and remember it as readable
  task automatic load_vector(input logic [9:0] idx, input logic [31:0] val, input bit last);
    in_item_t it;
    it.cmd        = CMD_LOAD;
    it.index      = idx;
    it.item_value = val;
    it.padding    = 1'($urandom);
    it.row_last   = last;
    it.prior_out  = $urandom;
    if (idx < VEC_DEPTH && !col_loaded[idx]) begin
      col_loaded[idx] = 1'b1;
      loaded_cols.push_back(idx);
    end
    send_item(it);
  endtask

  task automatic send_slot(input logic [9:0] col, input logic [31:0] val, input bit pad,
                           input bit last, input logic [31:0] prior);
    in_item_t it;
    it.cmd        = CMD_MATRIX;
    it.index      = col;
    it.item_value = val;
    it.padding    = pad;
    it.row_last   = last;
    it.prior_out  = prior;
    send_item(it);
    if (last)
      rows_sent++;
  endtask

  // One complete row over loaded columns, with padding and a stray load now and then
  task automatic send_random_row();
    int len;
    bit pad;
    len = $urandom_range(1, 6);
    for (int s = 0; s < len; s++) begin
      if ($urandom_range(0, 99) < 5)
        load_vector(10'($urandom_range(0, 1023)), rand_q(), 1'($urandom));
      pad = ($urandom_range(0, 99) < 15);
      send_slot(pad ? 10'($urandom_range(0, 1023))
                    : loaded_cols[$urandom_range(0, loaded_cols.size() - 1)],
                rand_q(), pad, s == len - 1, rand_q());
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Drain the unit, then rewrite both scales (and poke the unused indexes)
  task automatic apply_setting(input logic [31:0] alpha, input logic [31:0] beta);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rows != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_SPARE_A_IDX, $urandom);
    write_reg(CFG_ALPHA_IDX, alpha);
    write_reg(CFG_SPARE_B_IDX, $urandom);
    write_reg(CFG_BETA_IDX, beta);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Stimulus
  initial begin
    logic [31:0] alpha;
    logic [31:0] beta;
    int          target;
    int          waited;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    end_check       <= 1'b0;
    item_ch.valid   <= 1'b0;
    item_ch.payload <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset scales: alpha 1.0, beta 0
    load_vector(10'd0, 32'h0002_0000, 1'b0);
    load_vector(10'd1023, 32'hFFFE_8000, 1'b0);
    load_vector(10'd5, Q_MAX, 1'b0);
    load_vector(10'd6, Q_MIN, 1'b0);
    // row_last on a load is ignored
    load_vector(10'd7, 32'h0003_0000, 1'b1);
    send_slot(10'd0, Q_ONE, 1'b0, 1'b0, rand_q());
    // beta zero drops prior_out entirely
    send_slot(10'd1023, Q_HALF, 1'b0, 1'b1, Q_MAX);
    // row made of one padding slot
    send_slot(10'd7, 32'h1234_5678, 1'b1, 1'b1, Q_MIN);
    // clip high, then clip low
    send_slot(10'd5, Q_MAX, 1'b0, 1'b0, 32'h0);
    send_slot(10'd5, Q_MAX, 1'b0, 1'b1, 32'h0);
    send_slot(10'd6, Q_MIN, 1'b0, 1'b1, 32'h0);
    send_slot(10'd5, Q_MIN, 1'b0, 1'b1, 32'h0);

    // Extreme scales: alpha*value clips before the second multiply
    apply_setting(Q_MAX, Q_MIN);
    send_slot(10'd0, Q_MAX, 1'b0, 1'b1, Q_MAX);
    send_slot(10'd1023, Q_MIN, 1'b0, 1'b1, Q_MIN);
    send_slot(10'd3, $urandom, 1'b1, 1'b1, Q_ONE);
    apply_setting(Q_MIN, Q_MAX);
    send_slot(10'd5, Q_MAX, 1'b0, 1'b1, Q_MAX);
    send_slot(10'd6, Q_MIN, 1'b0, 1'b0, Q_MIN);
    send_slot(10'd0, Q_ONE, 1'b1, 1'b1, Q_MIN);

    // Random rows under varied scales; idle pattern shifts every two phases
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      send_idle_pct <= (phase < 2) ? 27 : (phase < 4) ? 68 : 0;
      recv_idle_pct <= (phase < 2) ? 68 : (phase < 4) ? 27 : 0;
      case (phase)
        0: begin
          alpha = Q_HALF;
          beta  = Q_ONE;
        end
        1: begin
          alpha = int'($urandom_range(0, 1 << 19)) - (1 << 18);
          beta  = int'($urandom_range(0, 1 << 18)) - (1 << 17);
        end
        2: begin
          alpha = Q_ONE;
          beta  = 32'h0;
        end
        3: begin
          alpha = $urandom;
          beta  = $urandom;
        end
        4: begin
          alpha = 32'h0;
          beta  = Q_NEG_ONE;
        end
        default: begin
          alpha = Q_NEG_ONE;
          beta  = 32'h0000_4000;
        end
      endcase
      apply_setting(alpha, beta);
      repeat (16) load_vector(10'($urandom_range(0, 1023)), rand_q(), 1'($urandom));
      target = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 20)
          load_vector(10'($urandom_range(0, 1023)), rand_q(), 1'($urandom));
        else
          send_random_row();
      end
    end

    // Drain, settle, then flush whatever is still outstanding
    item_ch.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending_rows != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Summary: %0d items (vector loads and ELLPACK slots) over %0d scale settings,",
             items_sent, settings_used);
    $display("  %0d rows sent, %0d row results compared (%0d clipped)",
             rows_sent, rows_checked, rows_clipped);
    if (mismatches == 0) begin
      $display("tb_ell_sparse_matvec_unit: clean");
    end else begin
      $display("tb_ell_sparse_matvec_unit: errors");
    end
    $finish;
  end

endmodule
